// ===== hw/rtl/ptrc_pkg.sv =====
// Package for the ppm trim pulse-rate calculator.
// Holds widths, constants, register indexes and the divider status type.
// No dependencies.
package ptrc_pkg;

  localparam int TrimW  = 18;
  localparam int MagW   = 17;
  localparam int QuotW  = 29;
  localparam int DivW   = 8;
  localparam int PerW   = 16;

  localparam int DivSteps = QuotW;
  localparam int CntW     = $clog2(DivSteps);

  // 307200000 / (mag / 256 * 262.144) reduced to exact integer form
  localparam logic [QuotW-1:0] PeriodNum = 29'd300000000;
  localparam logic [QuotW-1:0] PeriodMax = 29'h10000;
  localparam logic [QuotW-1:0] PeriodMin = 29'd4;

  localparam logic [DivW-1:0] NominalDiv = 8'd128;
  localparam logic [DivW-1:0] PosDiv     = 8'd129;
  localparam logic [DivW-1:0] NegDiv     = 8'd127;
  localparam logic [DivW-1:0] ClkDivMax  = 8'd128;

  // configuration register indexes
  localparam logic [1:0] CfgEnable    = 2'd0;
  localparam logic [1:0] CfgTrimLimit = 2'd1;
  localparam logic [1:0] CfgParkBelow = 2'd2;

  localparam logic [MagW-1:0] TrimLimitRst = 17'd76800;
  localparam logic [MagW-1:0] ParkBelowRst = 17'd30;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/ptrc_div.sv =====
// Restoring bit-serial divider: constant numerator over a 17-bit divisor.
// One quotient bit per cycle. Uses ptrc_pkg.
// Divisor zero yields an all-ones quotient.
module ptrc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptrc_pkg::MagW-1:0]     divisor,
  output logic [ptrc_pkg::QuotW-1:0]    quotient,
  output ptrc_pkg::div_stat_t           stat
);

  logic                          busy;
  logic                          done;
  logic [ptrc_pkg::CntW-1:0]     cnt;
  logic [ptrc_pkg::MagW-1:0]     rem;
  logic [ptrc_pkg::MagW-1:0]     rem_next;
  logic [ptrc_pkg::QuotW-1:0]    q;
  logic [ptrc_pkg::MagW-1:0]     dvs;
  logic [ptrc_pkg::MagW:0]       trial;
  logic [ptrc_pkg::MagW:0]       diff;
  logic                          ge;

  // numerator shifts out of q's top as quotient bits shift in at the bottom
  assign trial    = {rem, q[ptrc_pkg::QuotW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign rem_next = ge ? diff[ptrc_pkg::MagW-1:0] : trial[ptrc_pkg::MagW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ptrc_pkg::CntW'(ptrc_pkg::DivSteps - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= ptrc_pkg::PeriodNum;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[ptrc_pkg::QuotW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hw/rtl/ppm_trim_pulse_rate_calc_core.sv =====
// ppm trim pulse-rate calculator, top level.
// Uses ptrc_pkg and ptrc_div (bit-serial divider).
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 enable,
//    1 trim_limit, 2 park_below. cfg_ready is always high; index 3 is ignored.
//    Write only while the block is idle.
//  - Input channel (in_valid/in_ready, trim_request): one signed request in
//    1/256 ppm. in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready, result fields): one result item per
//    request, held in an output register.
// Flow: disabled or parked requests go from accept to the done state, then to
//  the output register. Active requests run the 29-step serial divider (one
//  quotient bit a cycle), a load step, up to 7 period-halving steps and a
//  clamp step before the done state.
//  A new request is accepted only after the last one has left the sequencer
//  for the output register.
// Stall: a finished result waits in the output register; the next request can
//  be accepted and worked on meanwhile, and its result waits in the sequencer
//  until the output register frees.
// Reset (rst, synchronous): registers return to enable 0, trim_limit 76800,
//  park_below 30; the sequencer idles and out_valid drops.
module ppm_trim_pulse_rate_calc_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ptrc_pkg::MagW-1:0]     cfg_data,
  // request
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ptrc_pkg::TrimW-1:0] trim_request,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          applied,
  output logic                          clamped,
  output logic signed [ptrc_pkg::TrimW-1:0] trim_applied,
  output logic                          parked,
  output logic [ptrc_pkg::DivW-1:0]     feedback_divider,
  output logic [ptrc_pkg::DivW-1:0]     clock_divider,
  output logic [ptrc_pkg::PerW-1:0]     period_minus_one
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic                          enable;
  logic [ptrc_pkg::MagW-1:0]     trim_limit;
  logic [ptrc_pkg::MagW-1:0]     park_below;

  // request front end (combinational, at accept)
  logic                          in_acc;
  logic                          neg;
  logic [ptrc_pkg::TrimW-1:0]    mag;
  logic                          over;
  logic [ptrc_pkg::MagW-1:0]     mag_c;
  logic [ptrc_pkg::TrimW-1:0]    trim_c;
  logic                          park_c;

  // working result
  logic                          w_applied;
  logic                          w_clamped;
  logic [ptrc_pkg::TrimW-1:0]    w_trim;
  logic                          w_parked;
  logic [ptrc_pkg::DivW-1:0]     w_fbdiv;
  logic [ptrc_pkg::DivW-1:0]     cdiv;
  logic [ptrc_pkg::QuotW-1:0]    period;
  logic [ptrc_pkg::PerW-1:0]     w_pm1;

  // divider
  logic                          div_start;
  logic [ptrc_pkg::QuotW-1:0]    quotient;
  ptrc_pkg::div_stat_t           div_stat;

  logic                          halve;
  logic                          out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      trim_limit <= ptrc_pkg::TrimLimitRst;
      park_below <= ptrc_pkg::ParkBelowRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ptrc_pkg::CfgEnable:    enable     <= cfg_data[0];
        ptrc_pkg::CfgTrimLimit: trim_limit <= cfg_data;
        ptrc_pkg::CfgParkBelow: park_below <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitude; the most negative request gives 0x20000, above any limit
  assign neg    = trim_request[ptrc_pkg::TrimW-1];
  assign mag    = neg ? (ptrc_pkg::TrimW'(0) - trim_request) : trim_request;
  assign over   = (mag > {1'b0, trim_limit});
  assign mag_c  = over ? trim_limit : mag[ptrc_pkg::MagW-1:0];
  assign trim_c = neg ? (ptrc_pkg::TrimW'(0) - {1'b0, mag_c}) : {1'b0, mag_c};
  assign park_c = (mag_c < park_below);

  // divider starts on the accept of an enabled, unparked request
  assign div_start = in_acc && enable && !park_c;

  ptrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (mag_c),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign halve    = (period > ptrc_pkg::PeriodMax) && (cdiv < ptrc_pkg::ClkDivMax);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) state <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_stat.done) state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (!halve) state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_applied <= enable;
      w_clamped <= enable && over;
      w_trim    <= enable ? trim_c : '0;
      w_parked  <= enable && park_c;
      // a zero magnitude that is not parked counts as not positive
      w_fbdiv   <= (!enable || park_c) ? ptrc_pkg::NominalDiv :
                   (!neg && (mag_c != '0)) ? ptrc_pkg::PosDiv : ptrc_pkg::NegDiv;
      cdiv      <= '0;
      w_pm1     <= '0;
    end else if (state == S_DIV && div_stat.done) begin
      period <= quotient;
      cdiv   <= 8'd1;
    end else if (state == S_SHIFT) begin
      if (halve) begin
        period <= period >> 1;
        cdiv   <= cdiv << 1;
      end else if (period > ptrc_pkg::PeriodMax) begin
        w_pm1 <= ptrc_pkg::PerW'(ptrc_pkg::PeriodMax - 1'b1);
      end else if (period < ptrc_pkg::PeriodMin) begin
        w_pm1 <= ptrc_pkg::PerW'(ptrc_pkg::PeriodMin - 1'b1);
      end else begin
        w_pm1 <= period[ptrc_pkg::PerW-1:0] - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      applied          <= w_applied;
      clamped          <= w_clamped;
      trim_applied     <= w_trim;
      parked           <= w_parked;
      feedback_divider <= w_fbdiv;
      clock_divider    <= cdiv;
      period_minus_one <= w_pm1;
    end
  end

  // checks
  a_park_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parked |-> (clock_divider == '0) && (period_minus_one == '0))
    else $error("parked result with nonzero divider or period");

  a_cdiv_pow2: assert property (@(posedge clk) disable iff (rst)
    out_valid && applied && !parked |-> $onehot(clock_divider))
    else $error("clock divider not a power of two");

  a_disabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !applied |->
      (feedback_divider == ptrc_pkg::NominalDiv) && !clamped && !parked)
    else $error("disabled result not neutral");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_stat.busy && (state == S_DIV))
    else $error("divider did not start with the sequencer");

endmodule

// ===== verif/tb_ppm_trim_pulse_rate_calc_core.sv =====
// Self-checking testbench for ppm_trim_pulse_rate_calc_core.
// Drives trim requests and register writes and checks every result item
// against an in-bench predictor. Depends on ptrc_pkg and the core RTL.
module tb_ppm_trim_pulse_rate_calc_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CycleLimit = 400000;
  localparam int          SettleCyc  = 45;
  localparam logic [1:0]  CfgUnused  = 2'd3; // decoded by nobody, must be ignored

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one expected result item
  typedef struct packed {
    logic                              applied;
    logic                              clamped;
    logic signed [ptrc_pkg::TrimW-1:0] trim_applied;
    logic                              parked;
    logic [ptrc_pkg::DivW-1:0]         feedback_divider;
    logic [ptrc_pkg::DivW-1:0]         clock_divider;
    logic [ptrc_pkg::PerW-1:0]         period_minus_one;
  } pulse_rate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [1:0]                        cfg_index = '0;
  logic [ptrc_pkg::MagW-1:0]         cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic signed [ptrc_pkg::TrimW-1:0] trim_request = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              applied;
  logic                              clamped;
  logic signed [ptrc_pkg::TrimW-1:0] trim_applied;
  logic                              parked;
  logic [ptrc_pkg::DivW-1:0]         feedback_divider;
  logic [ptrc_pkg::DivW-1:0]         clock_divider;
  logic [ptrc_pkg::PerW-1:0]         period_minus_one;

  ppm_trim_pulse_rate_calc_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .trim_request     (trim_request),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .applied          (applied),
    .clamped          (clamped),
    .trim_applied     (trim_applied),
    .parked           (parked),
    .feedback_divider (feedback_divider),
    .clock_divider    (clock_divider),
    .period_minus_one (period_minus_one)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  logic [ptrc_pkg::TrimW-1:0] pending_req[$];      // requests waiting for the driver
  pulse_rate_t                expected_rate[$];    // predicted results, oldest first

  // shadow of the block's registers, updated on each accepted write
  logic                       trim_en;
  logic [ptrc_pkg::MagW-1:0]  trim_lim;
  logic [ptrc_pkg::MagW-1:0]  park_thr;

  int req_sent     = 0;   // items put on the input port
  int req_accepted = 0;   // items taken by the block
  int res_seen     = 0;
  int res_parked   = 0;
  int res_clamped  = 0;
  int cfg_writes   = 0;
  int mismatches   = 0;
  int cycles       = 0;
  int hold_cycles  = 0;   // long receiver hold-off, counted down by the ready process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor: if enabled, saturate, park check, then floor(300e6 / mag) folded into
  // the 16-bit period by doubling the clock divider up to 128, then clamped.
  // ---------------------------------------------------------------------------
  function automatic pulse_rate_t calc_pulse_rate(input logic [ptrc_pkg::TrimW-1:0] req);
    pulse_rate_t                r;
    logic                       neg;
    logic [ptrc_pkg::TrimW-1:0] mag;
    logic [ptrc_pkg::TrimW-1:0] mag_c;
    logic [31:0]                period;
    logic [ptrc_pkg::DivW-1:0]  div;
    r.applied          = 1'b0;
    r.clamped          = 1'b0;
    r.trim_applied     = '0;
    r.parked           = 1'b0;
    r.feedback_divider = ptrc_pkg::NominalDiv;
    r.clock_divider    = '0;
    r.period_minus_one = '0;
    neg = req[ptrc_pkg::TrimW-1];
    // most negative request gives 0x20000, above any limit
    mag = neg ? ptrc_pkg::TrimW'(-req) : req;
    if (!trim_en) return r;
    r.applied = 1'b1;
    mag_c = mag;
    if (mag > {1'b0, trim_lim}) begin
      mag_c     = {1'b0, trim_lim};
      r.clamped = 1'b1;
    end
    r.trim_applied = neg ? ptrc_pkg::TrimW'(-mag_c) : mag_c;
    if (mag_c < {1'b0, park_thr}) begin
      r.parked = 1'b1;
    end else begin
      r.feedback_divider = (!neg && mag_c != 0) ? ptrc_pkg::PosDiv : ptrc_pkg::NegDiv;
      // zero magnitude (park threshold 0): divide saturates to all ones
      period = (mag_c != 0) ? 32'(ptrc_pkg::PeriodNum) / 32'(mag_c) : 32'hFFFF_FFFF;
      div = 8'd1;
      while (period > 32'(ptrc_pkg::PeriodMax) && div < ptrc_pkg::ClkDivMax) begin
        period = period >> 1;
        div    = div << 1;
      end
      if (period > 32'(ptrc_pkg::PeriodMax)) period = 32'(ptrc_pkg::PeriodMax);
      if (period < 32'(ptrc_pkg::PeriodMin)) period = 32'(ptrc_pkg::PeriodMin);
      r.clock_divider    = div;
      r.period_minus_one = ptrc_pkg::PerW'(period - 1);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ERROR result %0d %s: got %0d, expected %0d",
               $time, res_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, holds the item until taken.
  // req_accepted catching up with req_sent means the current item was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted == req_sent) begin
      if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        trim_request <= pending_req.pop_front();
        in_valid     <= 1'b1;
        req_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, or a long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples all handshakes at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_rate_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d items still expected",
               cycles, expected_rate.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst) begin
      trim_en  = 1'b0;
      trim_lim = ptrc_pkg::TrimLimitRst;
      park_thr = ptrc_pkg::ParkBelowRst;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          ptrc_pkg::CfgEnable:    trim_en  = cfg_data[0];
          ptrc_pkg::CfgTrimLimit: trim_lim = cfg_data;
          ptrc_pkg::CfgParkBelow: park_thr = cfg_data;
          default: ;
        endcase
      end
      // result side first; a request taken this edge cannot already be out
      if (out_valid && out_ready) begin
        res_seen++;
        if (expected_rate.size() == 0) begin
          flag_mismatch("unexpected item", 1, 0);
        end else begin
          want = expected_rate.pop_front();
          if (applied !== want.applied)
            flag_mismatch("applied", applied, want.applied);
          if (clamped !== want.clamped)
            flag_mismatch("clamped", clamped, want.clamped);
          if (trim_applied !== want.trim_applied)
            flag_mismatch("trim_applied", int'(trim_applied), int'(want.trim_applied));
          if (parked !== want.parked)
            flag_mismatch("parked", parked, want.parked);
          if (feedback_divider !== want.feedback_divider)
            flag_mismatch("feedback_divider", feedback_divider, want.feedback_divider);
          if (clock_divider !== want.clock_divider)
            flag_mismatch("clock_divider", clock_divider, want.clock_divider);
          if (period_minus_one !== want.period_minus_one)
            flag_mismatch("period_minus_one", period_minus_one, want.period_minus_one);
          if (want.parked)  res_parked++;
          if (want.clamped) res_clamped++;
        end
      end
      if (in_valid && in_ready) begin
        req_accepted++;
        expected_rate.push_back(calc_pulse_rate(trim_request));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  // wait until every queued request has produced its result
  task automatic drain;
    while (pending_req.size() != 0 || req_sent != req_accepted ||
           expected_rate.size() != 0)
      @(negedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [ptrc_pkg::MagW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 31 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 31 : 0;
  endtask

  function automatic logic [ptrc_pkg::TrimW-1:0] signed_req(input int mag, input bit neg);
    if (mag < 0)      mag = 0;
    if (mag > 131071) mag = 131071;
    return neg ? ptrc_pkg::TrimW'(-mag) : ptrc_pkg::TrimW'(mag);
  endfunction

  // random request, biased toward the park and clamp boundaries
  function automatic logic [ptrc_pkg::TrimW-1:0] rand_request(input int lim, input int thr);
    bit neg;
    neg = $urandom_range(1);
    case ($urandom_range(6))
      0, 1:    return ptrc_pkg::TrimW'($urandom);
      2:       return signed_req(thr + $urandom_range(6) - 3, neg);
      3:       return signed_req(lim + $urandom_range(6) - 3, neg);
      4:       return signed_req($urandom_range(2000), neg);
      5:       return signed_req($urandom_range(8000, 2000), neg);
      default: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return 18'sd131071;
          2:       return 18'h20000;   // most negative
          3:       return '1;          // -1
          default: return 18'sd1;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int lim;
    int thr;
    bit en;
    idle_mode_t mode;

    set_idle(IDLE_NONE);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disabled after reset: every request reports nothing applied
    pending_req = '{18'sd0, 18'sd131071, 18'h20000, 18'h3FFFF};
    drain();

    // Reset limits, enabled. Park edge at 30, clamp edge at 76800,
    // divider folding edge near mag 4578 (period 65530 vs 65545 at 4577),
    // mag 1 parks below the threshold.
    write_reg(ptrc_pkg::CfgEnable, 17'h1);
    pending_req = '{18'sd0, 18'sd1, 18'sd29, 18'sd30, -18'sd30, 18'sd76800,
                    18'sd76801, -18'sd76801, 18'sd4577, 18'sd4578, -18'sd300};
    drain();

    // Widest limit, no park: zero magnitude runs the saturated divide,
    // most negative request still clamps
    write_reg(ptrc_pkg::CfgTrimLimit, 17'h1FFFF);
    write_reg(ptrc_pkg::CfgParkBelow, 17'h0);
    pending_req = '{18'sd0, 18'h20000, 18'sd131071, -18'sd131071};
    drain();

    // Zero limit: every request saturates to zero
    write_reg(ptrc_pkg::CfgTrimLimit, 17'h0);
    pending_req = '{18'sd5, -18'sd5};
    drain();
    // and with the largest park threshold -7 parks, while 131071 on the edge does not
    write_reg(ptrc_pkg::CfgParkBelow, 17'h1FFFF);
    write_reg(ptrc_pkg::CfgTrimLimit, 17'h1FFFF);
    pending_req = '{-18'sd7, 18'sd131071};
    drain();
    // unused register index must change nothing
    write_reg(CfgUnused, ptrc_pkg::MagW'($urandom));

    // Random phases: 12 x 50 requests, each with its own settings and idling
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(5))
        0:       lim = 131071;
        1:       lim = 76800;
        2:       lim = $urandom_range(5000, 1);
        3:       lim = 1;
        default: lim = $urandom_range(131071, 1);
      endcase
      case ($urandom_range(5))
        0:       thr = 0;
        1:       thr = 30;
        2:       thr = $urandom_range(200);
        3:       thr = (ph == 7) ? 131071 : $urandom_range(3000);
        default: thr = $urandom_range(lim);
      endcase
      en = (ph != 3);
      // upper data bits of the enable write are don't-care
      write_reg(ptrc_pkg::CfgEnable, {(ptrc_pkg::MagW-1)'($urandom), en});
      write_reg(ptrc_pkg::CfgTrimLimit, ptrc_pkg::MagW'(lim));
      write_reg(ptrc_pkg::CfgParkBelow, ptrc_pkg::MagW'(thr));
      mode = idle_mode_t'(ph % 4);
      set_idle(mode);
      if (ph == 5) begin
        // sender keeps offering while the receiver is held off long enough
        // for the result register and the sequencer to fill
        set_idle(IDLE_NONE);
        @(posedge clk);
        hold_cycles = 300;
      end
      for (int i = 0; i < 50; i++)
        pending_req.push_back(rand_request(lim, thr));
      drain();
    end

    set_idle(IDLE_NONE);
    repeat (SettleCyc) @(posedge clk);
    if (expected_rate.size() != 0)
      flag_mismatch("results missing at end", 0, expected_rate.size());

    $display("Covered %0d requests and %0d results (%0d parked, %0d clamped),",
             req_accepted, res_seen, res_parked, res_clamped);
    $display("%0d register writes across 17 settings, %0d mismatches.",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
